>>> hdl/sls_pkg.sv
`timescale 1ns / 1ps

package sls_pkg;

  // Field widths fixed by the interface.
  localparam int REG_BITS     = 20;
  localparam int MODE_BITS    = 2;
  localparam int STEP_BITS    = 16;
  localparam int POS_OUT_BITS = 32;
  localparam int CFG_IDX_BITS = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_START  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_END    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPLICE = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_LOOP   = 2'd3;

  // Loop mode codes. The unused fourth code behaves as alternating.
  localparam logic [MODE_BITS-1:0] LOOP_ONE_SHOT  = 2'd0;
  localparam logic [MODE_BITS-1:0] LOOP_REPEAT    = 2'd1;
  localparam logic [MODE_BITS-1:0] LOOP_ALTERNATE = 2'd2;

  // Item command codes.
  localparam logic CMD_ADVANCE = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  typedef struct packed {
    logic [REG_BITS-1:0]  start_point;
    logic [REG_BITS-1:0]  end_point;
    logic [REG_BITS-1:0]  splice_point;
    logic [MODE_BITS-1:0] loop_mode;
  } sls_cfg_t;

  typedef struct packed {
    logic done;
    logic forward;
  } sls_flags_t;

endpackage

>>> hdl/sls_cfg.sv
`timescale 1ns / 1ps

module sls_cfg #(
  parameter int INDEX_BITS = 20
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [sls_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [sls_pkg::REG_BITS-1:0]      cfg_wdata,
  output sls_pkg::sls_cfg_t                 cfg_o
);

  // Index registers keep only the bits that the position format can hold.
  localparam logic [sls_pkg::REG_BITS-1:0] IDX_MASK =
    (INDEX_BITS >= sls_pkg::REG_BITS) ? {sls_pkg::REG_BITS{1'b1}}
                                      : sls_pkg::REG_BITS'((64'd1 << INDEX_BITS) - 64'd1);

  sls_pkg::sls_cfg_t cfg_r;
  sls_pkg::sls_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        sls_pkg::REG_START:  cfg_nxt.start_point  = cfg_wdata & IDX_MASK;
        sls_pkg::REG_END:    cfg_nxt.end_point    = cfg_wdata & IDX_MASK;
        sls_pkg::REG_SPLICE: cfg_nxt.splice_point = cfg_wdata & IDX_MASK;
        sls_pkg::REG_LOOP:   cfg_nxt.loop_mode    = cfg_wdata[sls_pkg::MODE_BITS-1:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_point  <= '0;
      cfg_r.end_point    <= IDX_MASK;
      cfg_r.splice_point <= '0;
      cfg_r.loop_mode    <= sls_pkg::LOOP_ONE_SHOT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

>>> hdl/sls_step.sv
`timescale 1ns / 1ps

module sls_step #(
  parameter int INDEX_BITS = 20,
  parameter int FRAC_BITS  = 12
) (
  input  sls_pkg::sls_cfg_t                  cfg_i,
  input  logic                               mode_i,
  input  logic [sls_pkg::STEP_BITS-1:0]      step_i,
  input  logic                               hold_i,
  input  logic [INDEX_BITS+FRAC_BITS-1:0]    pos_i,
  input  sls_pkg::sls_flags_t                flags_i,
  output logic [INDEX_BITS+FRAC_BITS-1:0]    pos_o,
  output sls_pkg::sls_flags_t                flags_o
);

  localparam int POS_BITS = INDEX_BITS + FRAC_BITS;
  // One spare bit above the wider of position and step catches carries.
  localparam int SUM_BITS =
    ((POS_BITS > sls_pkg::STEP_BITS) ? POS_BITS : sls_pkg::STEP_BITS) + 1;
  localparam logic [SUM_BITS-1:0] POS_MAX = SUM_BITS'({POS_BITS{1'b1}});
  localparam logic [SUM_BITS-1:0] FIX_ONE = SUM_BITS'(1) << FRAC_BITS;

  logic [POS_BITS-1:0] s_q, e_q, sp_q;
  logic [SUM_BITS-1:0] s_w, e_w, sp_w, pos_w, step_w;
  logic [SUM_BITS-1:0] sum_up, next_up, next_dn, next_w;
  logic [SUM_BITS-1:0] lim_up_sum, lim_up, lim_dn, splice_w;
  logic                reverse, upward, reach_end, reach_splice, halt_at_end, repeat_mode;
  logic [SUM_BITS-1:0] res_w;

  assign s_q  = POS_BITS'(cfg_i.start_point)  << FRAC_BITS;
  assign e_q  = POS_BITS'(cfg_i.end_point)    << FRAC_BITS;
  assign sp_q = POS_BITS'(cfg_i.splice_point) << FRAC_BITS;

  assign s_w    = SUM_BITS'(s_q);
  assign e_w    = SUM_BITS'(e_q);
  assign sp_w   = SUM_BITS'(sp_q);
  assign pos_w  = SUM_BITS'(pos_i);
  assign step_w = SUM_BITS'(step_i);

  assign reverse = e_w < s_w;
  assign upward  = flags_i.forward != reverse;

  // Saturating move in the current travel direction.
  assign sum_up  = pos_w + step_w;
  assign next_up = (sum_up > POS_MAX) ? POS_MAX : sum_up;
  assign next_dn = (step_w > pos_w) ? '0 : pos_w - step_w;
  assign next_w  = upward ? next_up : next_dn;

  // The splice point sits at least one sample inside the end point.
  assign lim_up_sum = e_w + FIX_ONE;
  assign lim_up     = (lim_up_sum > POS_MAX) ? POS_MAX : lim_up_sum;
  assign lim_dn     = (e_w < FIX_ONE) ? '0 : e_w - FIX_ONE;
  assign splice_w   = reverse ? ((sp_w > lim_up) ? sp_w : lim_up)
                              : ((sp_w < lim_dn) ? sp_w : lim_dn);

  assign reach_end    = reverse ? (next_w <= e_w) : (next_w >= e_w);
  assign reach_splice = reverse ? (next_w >= splice_w) : (next_w <= splice_w);

  assign halt_at_end = cfg_i.loop_mode == sls_pkg::LOOP_ONE_SHOT;
  assign repeat_mode = cfg_i.loop_mode == sls_pkg::LOOP_REPEAT;

  always_comb begin
    flags_o = flags_i;
    res_w   = pos_w;
    if (mode_i == sls_pkg::CMD_RESTART) begin
      res_w           = s_w;
      flags_o.done    = 1'b0;
      flags_o.forward = 1'b1;
    end else if (!flags_i.done && !hold_i) begin
      if (halt_at_end) begin
        if (reach_end) begin
          flags_o.done = 1'b1;
          res_w        = e_w;
        end else begin
          res_w = next_w;
        end
      end else if (flags_i.forward) begin
        if (reach_end) begin
          if (repeat_mode) begin
            res_w = splice_w;
          end else begin
            flags_o.forward = 1'b0;
            res_w           = e_w;
          end
        end else begin
          res_w = next_w;
        end
      end else if (reach_splice) begin
        flags_o.forward = 1'b1;
        res_w           = splice_w;
      end else begin
        res_w = next_w;
      end
    end
  end

  assign pos_o = POS_BITS'(res_w);

endmodule

>>> hdl/sample_loop_scanner.sv
`timescale 1ns / 1ps
// Data path: an accepted item is loaded into the input register, then passes through
// the combinational step logic into the state/result register once the result side
// does not stall. Throughput: one item per cycle while the result side does not
// stall; the rate is set by the combinational step logic that updates the position
// state register. Reset: synchronous, active low; it empties the pipeline and
// restores registers, position 0, finished 0, forward 1.

module sample_loop_scanner #(
  parameter int INDEX_BITS = 20,
  parameter int FRAC_BITS  = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration write port.
  input  logic                                cfg_we,
  input  logic [sls_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [sls_pkg::REG_BITS-1:0]        cfg_wdata,
  // Input item channel.
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_mode,
  input  logic [sls_pkg::STEP_BITS-1:0]       in_pitch_step,
  input  logic                                in_hold,
  // Result item channel.
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [sls_pkg::POS_OUT_BITS-1:0]    out_position,
  output logic                                out_finished,
  output logic                                out_heading_forward
);

  localparam int POS_BITS = INDEX_BITS + FRAC_BITS;

  // Configuration registers.
  sls_pkg::sls_cfg_t cfg;

  sls_cfg #(
    .INDEX_BITS (INDEX_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  // Input register stage. It holds one item while the result side is stalled,
  // so the channel can take one more item while a finished result waits.
  logic                          s1_valid_r;
  logic                          s1_mode_r;
  logic [sls_pkg::STEP_BITS-1:0] s1_step_r;
  logic                          s1_hold_r;

  // The scanner state doubles as the result register: it only changes when the
  // item in the input stage moves into the (empty or draining) result slot.
  logic [POS_BITS-1:0]  pos_r;
  logic [POS_BITS-1:0]  pos_nxt;
  sls_pkg::sls_flags_t  flags_r;
  sls_pkg::sls_flags_t  flags_nxt;
  logic                 out_valid_r;

  logic out_free;
  logic advance;
  logic in_take;

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  sls_step #(
    .INDEX_BITS (INDEX_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_step (
    .cfg_i   (cfg),
    .mode_i  (s1_mode_r),
    .step_i  (s1_step_r),
    .hold_i  (s1_hold_r),
    .pos_i   (pos_r),
    .flags_i (flags_r),
    .pos_o   (pos_nxt),
    .flags_o (flags_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      pos_r           <= '0;
      flags_r.done    <= 1'b0;
      flags_r.forward <= 1'b1;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        pos_r       <= pos_nxt;
        flags_r     <= flags_nxt;
      end else if (out_free) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item payload needs no reset; it is qualified by s1_valid_r.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_mode_r <= in_mode;
      s1_step_r <= in_pitch_step;
      s1_hold_r <= in_hold;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_position        = sls_pkg::POS_OUT_BITS'(pos_r);
  assign out_finished        = flags_r.done;
  assign out_heading_forward = flags_r.forward;

endmodule

>>> hdl/sls_checker.sv
`timescale 1ns / 1ps

module sls_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [sls_pkg::POS_OUT_BITS-1:0] out_position,
  input logic                             out_finished,
  input logic                             out_heading_forward
);

  // Nothing is offered on the result side right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // The input side only backs up when a result is waiting and stalled.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked result");

  a_hold_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_position)))
    else $error("stalled position changed");

  a_hold_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      ($stable(out_finished) && $stable(out_heading_forward)))
    else $error("stalled flags changed");

endmodule

bind sample_loop_scanner sls_checker u_sls_checker (.*);
